/* design/led_strip_effect_controller_defines.svh */
// ----------------------------------------------------------------------------
// LED strip effect controller assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_EFFECT_CONTROLLER_DEFINES_SVH
`define LED_STRIP_EFFECT_CONTROLLER_DEFINES_SVH

// Consequent checked in the cycle after the antecedent
`define LSEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("led strip controller: sequential check failed");

// Consequent checked in the same cycle as the antecedent
`define LSEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("led strip controller: same-cycle check failed");

`endif

/* design/lsec_pkg.sv */
// ----------------------------------------------------------------------------
// LED strip effect controller package
// Shared types, codes and reset constants.
// ----------------------------------------------------------------------------
package lsec_pkg;

    localparam int LED_COUNT_DEF = 10;
    localparam int QUEUE_DEPTH   = 2;

    // Command codes
    localparam logic [1:0] CMD_SET_MODE  = 2'd0;
    localparam logic [1:0] CMD_SET_COLOR = 2'd1;
    localparam logic [1:0] CMD_TICK      = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLINK_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_EFFECT_PERIOD = 2'd1;
    localparam logic [1:0] CFG_FADE_STEP     = 2'd2;

    localparam logic [7:0] BLINK_PERIOD_RESET  = 8'd10;
    localparam logic [7:0] EFFECT_PERIOD_RESET = 8'd1;
    localparam logic [7:0] FADE_STEP_RESET     = 8'd10;

    // LED modes
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_OFF        = 3'd0;
    localparam mode_t MODE_STEADY     = 3'd1;
    localparam mode_t MODE_BLINK      = 3'd2;
    localparam mode_t MODE_BLINK_DARK = 3'd3;
    localparam mode_t MODE_FADE       = 3'd4;
    localparam mode_t MODE_FADE_RG    = 3'd5;
    localparam mode_t MODE_FADE_GB    = 3'd6;
    localparam mode_t MODE_FADE_BR    = 3'd7;

    // Classified operations passed from front to back
    typedef logic [1:0] op_t;
    localparam op_t OP_SET_MODE  = 2'd0;
    localparam op_t OP_SET_COLOR = 2'd1;
    localparam op_t OP_SET_BAD   = 2'd2;
    localparam op_t OP_TICK      = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] first_led;
        logic [7:0] end_led;
        logic [2:0] new_mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } command_t;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_led;
    } result_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    typedef struct packed {
        logic [7:0] blink_period;
        logic [7:0] effect_period;
        logic [7:0] fade_step;
    } config_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] first_led;
        logic [7:0] end_led;
        mode_t      mode;
        color_t     color;
    } job_t;

    typedef struct packed {
        mode_t  mode;
        color_t base;
        color_t shown;
    } led_row_t;

    localparam led_row_t LED_ROW_RESET = '{mode: MODE_FADE, base: '0, shown: '0};

endpackage

/* design/lsec_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/lsec_front.sv */
// ----------------------------------------------------------------------------
// LED strip controller front end
// Accepts commands, checks set ranges and hands classified jobs to the queue.
// ----------------------------------------------------------------------------
module lsec_front
    import lsec_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  command_t command,
    output logic     busy,
    input  logic     queue_full,
    output logic     push,
    output job_t     job
);

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic accept;
    logic range_ok;
    logic keep;

    assign busy   = valid_reg && queue_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !queue_full;
    assign job    = job_reg;

    // Half-open range check against the strip length
    assign range_ok = (command.first_led < 8'(LED_COUNT)) &&
                      (command.end_led <= 8'(LED_COUNT)) &&
                      (command.first_led < command.end_led);

    // Classification
    always_comb
    begin
        job_next           = job_reg;
        keep               = 1'b1;
        job_next.first_led = command.first_led;
        job_next.end_led   = command.end_led;
        job_next.mode      = command.new_mode;
        job_next.color     = '{r: command.red_in, g: command.green_in, b: command.blue_in};
        case (command.cmd)
            CMD_SET_MODE:  job_next.op = range_ok ? OP_SET_MODE : OP_SET_BAD;
            CMD_SET_COLOR: job_next.op = range_ok ? OP_SET_COLOR : OP_SET_BAD;
            CMD_TICK:      job_next.op = OP_TICK;
            default:       keep = 1'b0;
        endcase
    end

    // Holding stage toward the queue
    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            job_reg <= job_next;
        end
    end

endmodule

/* design/lsec_queue.sv */
// ----------------------------------------------------------------------------
// LED strip controller job queue
// Short FIFO between the front end and the LED walker.
// ----------------------------------------------------------------------------
module lsec_queue
    import lsec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    job_t            entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/lsec_back.sv */
// ----------------------------------------------------------------------------
// LED strip controller back end
// Owns flags and timers and walks the LED table one LED per cycle.
// ----------------------------------------------------------------------------
module lsec_back
    import lsec_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  config_t cfg,
    input  job_t    job,
    input  logic    job_ready,
    output logic    job_pop,
    output logic    result_valid,
    output result_t result
);

    localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CntW  = $clog2(LED_COUNT + 1);
    localparam int RowW  = $bits(led_row_t);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    typedef struct packed {
        logic  set_mode;
        logic  set_color;
        logic  apply;
        logic  blink;
        logic  fade;
        logic  emit;
    } walk_ops_t;

    state_t           state_reg, state_next;
    logic             pending_reg, pending_next;
    logic             blocked_reg, blocked_next;
    logic [7:0]       blink_timer_reg, blink_timer_next;
    logic [7:0]       effect_timer_reg, effect_timer_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [CntW-1:0]  lim_reg, lim_next;
    walk_ops_t        ops_reg, ops_next;
    mode_t            set_mode_reg, set_mode_next;
    color_t           set_color_reg, set_color_next;
    logic [LED_COUNT-1:0] row_valid_reg, row_valid_next;
    logic             p1_valid_reg, p1_valid_next;
    logic [AddrW-1:0] p1_addr_reg, p1_addr_next;
    logic             p1_row_valid_reg, p1_row_valid_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    logic             issue;
    logic [AddrW-1:0] rd_addr;
    logic [RowW-1:0]  rd_data;
    led_row_t         row_in;
    led_row_t         row_out;
    logic             blink_due;
    logic             fade_due;
    logic             blk_after;
    logic             do_blink;
    logic             do_fade;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    function automatic logic [7:0] reload(input logic [7:0] period);
        reload = (period == 8'd0) ? 8'd0 : period - 8'd1;
    endfunction

    // Moves step from fall to rise; top bit flags the phase change
    function automatic logic [16:0] fade_move(input logic [7:0] fall,
                                              input logic [7:0] rise,
                                              input logic [7:0] step);
        logic [7:0] f;
        logic [7:0] r;
        f = fall - step;
        r = rise + step;
        fade_move = {(f <= step), f, r};
    endfunction

    // Tick decision, evaluated on the popped job
    assign blink_due = (blink_timer_reg == 8'd0);
    assign fade_due  = (effect_timer_reg == 8'd0);
    assign blk_after = pending_reg ? 1'b0 : blocked_reg;
    assign do_blink  = blink_due && !blk_after;
    assign do_fade   = fade_due && !blk_after;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        pending_next      = pending_reg;
        blocked_next      = blocked_reg;
        blink_timer_next  = blink_timer_reg;
        effect_timer_next = effect_timer_reg;
        cnt_next          = cnt_reg;
        lim_next          = lim_reg;
        ops_next          = ops_reg;
        set_mode_next     = set_mode_reg;
        set_color_next    = set_color_reg;
        job_pop           = 1'b0;
        issue             = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_ready)
                begin
                    job_pop        = 1'b1;
                    set_mode_next  = job.mode;
                    set_color_next = job.color;
                    ops_next       = '0;
                    case (job.op)
                        OP_SET_MODE, OP_SET_COLOR:
                        begin
                            blocked_next       = 1'b1;
                            pending_next       = 1'b1;
                            cnt_next           = CntW'(job.first_led);
                            lim_next           = CntW'(job.end_led);
                            ops_next.set_mode  = (job.op == OP_SET_MODE);
                            ops_next.set_color = (job.op == OP_SET_COLOR);
                            state_next         = ST_WALK;
                        end
                        OP_TICK:
                        begin
                            blink_timer_next  = do_blink ? reload(cfg.blink_period) :
                                                blink_due ? blink_timer_reg :
                                                blink_timer_reg - 8'd1;
                            effect_timer_next = do_fade ? reload(cfg.effect_period) :
                                                fade_due ? effect_timer_reg :
                                                effect_timer_reg - 8'd1;
                            pending_next      = 1'b0;
                            blocked_next      = blk_after;
                            ops_next.apply    = pending_reg;
                            ops_next.blink    = do_blink;
                            ops_next.fade     = do_fade;
                            ops_next.emit     = 1'b1;
                            cnt_next          = '0;
                            lim_next          = CntW'(LED_COUNT);
                            if (pending_reg || do_blink || do_fade)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            blocked_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                issue = (cnt_reg != lim_reg);
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!p1_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = cnt_reg[AddrW-1:0];

    lsec_ram #(
        .WIDTH(RowW),
        .DEPTH(LED_COUNT)
    ) u_row_ram (
        .clk    (clk),
        .wr_en  (p1_valid_reg),
        .wr_addr(p1_addr_reg),
        .wr_data(row_out),
        .rd_en  (issue),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Per-LED update: set, apply, blink, fade in that order
    always_comb
    begin
        logic [16:0] mv;
        row_in  = p1_row_valid_reg ? led_row_t'(rd_data) : LED_ROW_RESET;
        row_out = row_in;
        mv      = '0;
        if (ops_reg.set_mode)
        begin
            row_out.mode = set_mode_reg;
        end
        if (ops_reg.set_color)
        begin
            row_out.base = set_color_reg;
        end
        if (ops_reg.apply)
        begin
            row_out.shown = row_out.base;
            if (row_out.mode == MODE_OFF)
            begin
                row_out.shown = '0;
            end
            else if (row_out.mode == MODE_FADE)
            begin
                row_out.mode  = MODE_FADE_RG;
                row_out.shown = '{r: 8'hFF, g: 8'h00, b: 8'h00};
            end
        end
        if (ops_reg.blink)
        begin
            if (row_out.mode == MODE_BLINK_DARK)
            begin
                row_out.shown = '0;
                row_out.mode  = MODE_BLINK;
            end
            else if (row_out.mode == MODE_BLINK)
            begin
                row_out.shown = row_out.base;
                row_out.mode  = MODE_BLINK_DARK;
            end
        end
        if (ops_reg.fade)
        begin
            case (row_out.mode)
                MODE_FADE_RG:
                begin
                    mv = fade_move(row_out.shown.r, row_out.shown.g, cfg.fade_step);
                    row_out.shown.r = mv[15:8];
                    row_out.shown.g = mv[7:0];
                    if (mv[16]) row_out.mode = MODE_FADE_GB;
                end
                MODE_FADE_GB:
                begin
                    mv = fade_move(row_out.shown.g, row_out.shown.b, cfg.fade_step);
                    row_out.shown.g = mv[15:8];
                    row_out.shown.b = mv[7:0];
                    if (mv[16]) row_out.mode = MODE_FADE_BR;
                end
                MODE_FADE_BR:
                begin
                    mv = fade_move(row_out.shown.b, row_out.shown.r, cfg.fade_step);
                    row_out.shown.b = mv[15:8];
                    row_out.shown.r = mv[7:0];
                    if (mv[16]) row_out.mode = MODE_FADE_RG;
                end
                default:
                begin
                    mv = '0;
                end
            endcase
        end
    end

    // Read stage bookkeeping, valid bits and frame output
    always_comb
    begin
        p1_valid_next     = issue;
        p1_addr_next      = rd_addr;
        p1_row_valid_next = row_valid_reg[rd_addr];
        row_valid_next    = row_valid_reg;
        if (p1_valid_reg)
        begin
            row_valid_next[p1_addr_reg] = 1'b1;
        end
        result_valid_next     = p1_valid_reg && ops_reg.emit;
        result_next.led_index = 6'(p1_addr_reg);
        result_next.red_out   = row_out.shown.r;
        result_next.green_out = row_out.shown.g;
        result_next.blue_out  = row_out.shown.b;
        result_next.last_led  = (p1_addr_reg == AddrW'(LED_COUNT - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pending_reg      <= 1'b1;
            blocked_reg      <= 1'b0;
            blink_timer_reg  <= 8'd0;
            effect_timer_reg <= 8'd0;
            cnt_reg          <= '0;
            lim_reg          <= '0;
            ops_reg          <= '0;
            row_valid_reg    <= '0;
            p1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pending_reg      <= pending_next;
            blocked_reg      <= blocked_next;
            blink_timer_reg  <= blink_timer_next;
            effect_timer_reg <= effect_timer_next;
            cnt_reg          <= cnt_next;
            lim_reg          <= lim_next;
            ops_reg          <= ops_next;
            row_valid_reg    <= row_valid_next;
            p1_valid_reg     <= p1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        set_mode_reg     <= set_mode_next;
        set_color_reg    <= set_color_next;
        p1_addr_reg      <= p1_addr_next;
        p1_row_valid_reg <= p1_row_valid_next;
        result_reg       <= result_next;
    end

endmodule

/* design/led_strip_effect_controller.sv */
// A showing tick passes the front register, queue, walk state, RAM read and result
// register before LED 0 is on result. A frame is LED_COUNT results on consecutive cycles;
// the LED table walk (one RAM read and one write per LED) ends before the next pop.
// Set commands walk their range only; bad ranges and quiet ticks pop without a walk.
// Reset: per-LED state reads as reset through valid bits; no clearing pass.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// LED strip effect controller
// Per-LED blink and rainbow fade effects with frame output on each showing tick.
// ----------------------------------------------------------------------------
module led_strip_effect_controller
    import lsec_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  command_t   command,
    output logic       result_valid,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    config_t cfg_reg;
    config_t cfg_next;
    logic    queue_full;
    logic    queue_empty;
    logic    push;
    logic    pop;
    job_t    front_job;
    job_t    head_job;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLINK_PERIOD:  cfg_next.blink_period  = cfg_data;
                CFG_EFFECT_PERIOD: cfg_next.effect_period = cfg_data;
                CFG_FADE_STEP:     cfg_next.fade_step     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{blink_period:  BLINK_PERIOD_RESET,
                         effect_period: EFFECT_PERIOD_RESET,
                         fade_step:     FADE_STEP_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsec_front #(
        .LED_COUNT(LED_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .busy      (busy),
        .queue_full(queue_full),
        .push      (push),
        .job       (front_job)
    );

    lsec_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(front_job),
        .pop     (pop),
        .head    (head_job),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    lsec_back #(
        .LED_COUNT(LED_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job         (head_job),
        .job_ready   (!queue_empty),
        .job_pop     (pop),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

/* design/lsec_checker.sv */
// ----------------------------------------------------------------------------
// LED strip controller checker
// Frame ordering checks on the top-level result port.
// ----------------------------------------------------------------------------
`include "led_strip_effect_controller_defines.svh"

module lsec_checker
    import lsec_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input result_t result
);

    // A frame runs on consecutive cycles
    `LSEC_ASSERT_NEXT(a_frame_contiguous, clk, rst_n, result_valid && !result.last_led, result_valid)

    // LED index steps by one within a frame
    `LSEC_ASSERT_NEXT(a_index_step, clk, rst_n, result_valid && !result.last_led, result.led_index == $past(result.led_index) + 6'd1)

    // Last flag only on the final LED
    `LSEC_ASSERT_SAME(a_last_index, clk, rst_n, result_valid && result.last_led, result.led_index == 6'(LED_COUNT - 1))

    // Each frame starts at LED 0
    `LSEC_ASSERT_SAME(a_frame_start, clk, rst_n, $rose(result_valid), result.led_index == 6'd0)

endmodule

bind led_strip_effect_controller lsec_checker #(.LED_COUNT(LED_COUNT)) u_lsec_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_valid(result_valid),
    .result      (result)
);
